// File: rtl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types, codes and iteration steps of the trapezoid velocity planner.
// ----------------------------------------------------------------------------
package tvs_pkg;

	localparam int STEPS_PER_STAGE = 2;
	localparam int SQRT_STEPS      = 16;
	localparam int DIV_STEPS       = 20;
	localparam int SQ_WORK         = SQRT_STEPS / STEPS_PER_STAGE;
	localparam int CORE_STAGES     = DIV_STEPS / STEPS_PER_STAGE;
	localparam int FRONT_STAGES    = 5;
	localparam int PIPE_STAGES     = FRONT_STAGES + CORE_STAGES;

	localparam logic [2:0] PH_ZERO    = 3'd0;
	localparam logic [2:0] PH_ACCEL   = 3'd1;
	localparam logic [2:0] PH_CRUISE  = 3'd2;
	localparam logic [2:0] PH_DECEL   = 3'd3;
	localparam logic [2:0] PH_ARRIVED = 3'd4;

	localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
	localparam logic [2:0] REG_MIN_SPEED   = 3'd1;
	localparam logic [2:0] REG_MAX_ACCEL   = 3'd2;
	localparam logic [2:0] REG_FINAL_SPEED = 3'd3;
	localparam logic [2:0] REG_LOOK_AHEAD  = 3'd4;

	typedef struct packed {
		logic [14:0]        max_speed;
		logic signed [15:0] min_speed;
		logic [15:0]        max_accel;
		logic signed [15:0] final_speed;
		logic [15:0]        look_ahead;
	} cfg_t;

	typedef struct packed {
		logic               neg;
		logic               zero;
		logic               trap;
		logic               ph1t;
		logic               cmp2;
		logic               cmp3;
		logic [15:0]        vm;
		logic signed [16:0] vf;
		logic signed [18:0] s1;
		logic signed [18:0] base3;
		logic signed [18:0] u1;
		logic signed [18:0] u3;
		logic signed [18:0] w;
	} side_t;

	typedef struct packed {
		logic [31:0] x;
		logic [17:0] rem;
		logic [15:0] root;
	} sq_t;

	typedef struct packed {
		logic [19:0] num;
		logic [16:0] rem;
		logic [19:0] quo;
		logic [15:0] dvs;
	} dv_t;

	function automatic sq_t sq_step(input sq_t st);
		sq_t         o;
		logic [19:0] cur;
		logic [19:0] trial;
		cur   = {st.rem, st.x[31:30]};
		trial = {2'b00, st.root, 2'b01};
		o.x   = {st.x[29:0], 2'b00};
		if (cur >= trial) begin
			o.rem  = 18'(cur - trial);
			o.root = {st.root[14:0], 1'b1};
		end else begin
			o.rem  = cur[17:0];
			o.root = {st.root[14:0], 1'b0};
		end
		return o;
	endfunction

	function automatic dv_t dv_step(input dv_t st);
		dv_t         o;
		logic [17:0] cur;
		logic [17:0] dx;
		cur   = {st.rem, st.num[19]};
		dx    = {2'b00, st.dvs};
		o.num = {st.num[18:0], 1'b0};
		o.dvs = st.dvs;
		if (cur >= dx) begin
			o.rem = 17'(cur - dx);
			o.quo = {st.quo[18:0], 1'b1};
		end else begin
			o.rem = cur[16:0];
			o.quo = {st.quo[18:0], 1'b0};
		end
		return o;
	endfunction

endpackage

// File: rtl/tvs_front.sv
// ----------------------------------------------------------------------------
// tvs_front
// Five stages: mirror, products, leg tests, wide sums and compares.
// ----------------------------------------------------------------------------
module tvs_front import tvs_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  cfg_t               cfg,
	input  logic signed [15:0] start_speed,
	input  logic signed [16:0] distance,
	output side_t              side,
	output logic [34:0]        dvd,
	output logic [15:0]        dvs,
	output logic [31:0]        rad
);

	logic               neg_in;
	logic [16:0]        d_in;
	logic signed [16:0] v0_x, vf_x, minv;
	logic signed [16:0] v0_in, vf_in;
	logic [15:0]        vm_in, a_in;

	always_comb begin
		neg_in = distance[16];
		d_in   = neg_in ? 17'(-distance) : distance;
		v0_x   = {start_speed[15], start_speed};
		vf_x   = {cfg.final_speed[15], cfg.final_speed};
		minv   = -{cfg.min_speed[15], cfg.min_speed};
		v0_in  = neg_in ? -v0_x : v0_x;
		vf_in  = neg_in ? -vf_x : vf_x;
		if (neg_in) begin
			vm_in = (cfg.min_speed > 16'sd0) ? 16'd0 : minv[15:0];
		end else begin
			vm_in = {1'b0, cfg.max_speed};
		end
		a_in = (cfg.max_accel == 16'd0) ? 16'd1 : cfg.max_accel;
	end

	logic signed [16:0] v0_s1, vf_s1;
	logic [16:0]        d_s1;
	logic [15:0]        vm_s1, a_s1, t_s1;
	logic               neg_s1, zero_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			v0_s1   <= v0_in;
			vf_s1   <= vf_in;
			d_s1    <= d_in;
			vm_s1   <= vm_in;
			a_s1    <= a_in;
			t_s1    <= cfg.look_ahead;
			neg_s1  <= neg_in;
			zero_s1 <= (distance == 17'sd0);
		end
	end

	logic signed [17:0] vms_1, dv0_1, dvf_1;
	logic signed [33:0] v0sq_f, vfsq_f;
	logic signed [35:0] pv0_f, pvf_f;
	logic [31:0]        vmsq_f;

	always_comb begin
		vms_1  = $signed({2'b00, vm_s1});
		dv0_1  = vms_1 - $signed({v0_s1[16], v0_s1});
		dvf_1  = vms_1 - $signed({vf_s1[16], vf_s1});
		v0sq_f = 34'(v0_s1) * 34'(v0_s1);
		vfsq_f = 34'(vf_s1) * 34'(vf_s1);
		vmsq_f = 32'(vm_s1) * 32'(vm_s1);
		pv0_f  = 36'(vms_1) * 36'(dv0_1);
		pvf_f  = 36'(vms_1) * 36'(dvf_1);
	end

	logic [31:0]        at_s2;
	logic [32:0]        ad_s2;
	logic [30:0]        v0sq_s2, vfsq_s2, vmsq_s2;
	logic signed [33:0] pv0_s2, pvf_s2;
	logic signed [16:0] v0_s2, vf_s2;
	logic [15:0]        vm_s2;
	logic               neg_s2, zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			at_s2   <= 32'(a_s1) * 32'(t_s1);
			ad_s2   <= 33'(a_s1) * 33'(d_s1);
			v0sq_s2 <= v0sq_f[30:0];
			vfsq_s2 <= vfsq_f[30:0];
			vmsq_s2 <= vmsq_f[30:0];
			pv0_s2  <= pv0_f[33:0];
			pvf_s2  <= pvf_f[33:0];
			v0_s2   <= v0_s1;
			vf_s2   <= vf_s1;
			vm_s2   <= vm_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
		end
	end

	logic signed [34:0] tad_2, k_2, n_2;
	logic [34:0]        r_2;
	logic [32:0]        c_sum, h_sum;
	logic signed [33:0] tw_2;
	logic signed [18:0] v0e_2, vfe_2, c_2, h_2, vme_2;
	side_t              side_2;

	always_comb begin
		tad_2 = $signed({1'b0, ad_s2, 1'b0});
		k_2   = $signed({3'b000, vmsq_s2, 1'b0}) - $signed({4'b0000, v0sq_s2})
			- $signed({4'b0000, vfsq_s2});
		n_2   = tad_2 - k_2;
		r_2   = 35'(unsigned'(tad_2)) + {4'b0000, v0sq_s2} + {4'b0000, vfsq_s2};
		c_sum = {1'b0, at_s2} + 33'd65535;
		h_sum = {1'b0, at_s2} + 33'd32768;
		tw_2  = 34'sd32768 - $signed({2'b00, at_s2});
		v0e_2 = {{2{v0_s2[16]}}, v0_s2};
		vfe_2 = {{2{vf_s2[16]}}, vf_s2};
		c_2   = $signed({2'b00, c_sum[32:16]});
		h_2   = $signed({2'b00, h_sum[32:16]});
		vme_2 = $signed({3'b000, vm_s2});

		side_2.neg   = neg_s2;
		side_2.zero  = zero_s2;
		side_2.trap  = tad_2 > k_2;
		side_2.u1    = v0e_2 + c_2;
		side_2.u3    = v0e_2 + vfe_2 + c_2;
		side_2.ph1t  = vme_2 >= side_2.u1;
		side_2.cmp2  = 1'b0;
		side_2.cmp3  = 1'b0;
		side_2.vm    = vm_s2;
		side_2.vf    = vf_s2;
		side_2.s1    = v0e_2 + h_2;
		side_2.base3 = $signed({2'b00, vm_s2, 1'b0}) - v0e_2;
		side_2.w     = {tw_2[33], tw_2[33:16]} - v0e_2;
	end

	logic signed [34:0] n_s3;
	logic [31:0]        rad_s3;
	logic [47:0]        vmat_s3;
	logic signed [33:0] pv0_s3, pvf_s3;
	side_t              side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3    <= n_2;
			rad_s3  <= r_2[32:1];
			vmat_s3 <= 48'(vm_s2) * 48'(at_s2);
			pv0_s3  <= pv0_s2;
			pvf_s3  <= pvf_s2;
			side_s3 <= side_2;
		end
	end

	logic signed [36:0] x_3, y_3;
	logic signed [51:0] m_3;

	always_comb begin
		x_3 = 37'(n_s3) + 37'($signed({pv0_s3, 1'b0}));
		y_3 = x_3 + 37'($signed({pvf_s3, 1'b0}));
		m_3 = $signed({n_s3[34], n_s3, 16'h0000})
			- $signed({3'b000, vmat_s3, 1'b0})
			+ $signed({20'h00000, side_s3.vm, 16'h0000});
	end

	logic signed [36:0] x_s4, y_s4;
	logic signed [51:0] m_s4;
	logic [47:0]        vmat_s4;
	logic [31:0]        rad_s4;
	side_t              side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4    <= x_3;
			y_s4    <= y_3;
			m_s4    <= m_3;
			vmat_s4 <= vmat_s3;
			rad_s4  <= rad_s3;
			side_s4 <= side_s3;
		end
	end

	logic signed [53:0] lhs_4, xs_4, ys_4;
	side_t              side_4;

	always_comb begin
		lhs_4       = $signed({5'b00000, vmat_s4, 1'b0});
		xs_4        = $signed({x_s4[36], x_s4, 16'h0000});
		ys_4        = $signed({y_s4[36], y_s4, 16'h0000});
		side_4      = side_s4;
		side_4.cmp2 = lhs_4 <= xs_4;
		side_4.cmp3 = lhs_4 <= ys_4;
	end

	logic [34:0] dvd_s5;
	logic [15:0] vm_s5;
	logic [31:0] rad_s5;
	side_t       side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s5  <= m_s4[51:17] + {1'b0, side_s4.vm, 18'h00000};
			vm_s5   <= side_s4.vm;
			rad_s5  <= rad_s4;
			side_s5 <= side_4;
		end
	end

	assign side = side_s5;
	assign dvd  = dvd_s5;
	assign dvs  = vm_s5;
	assign rad  = rad_s5;

endmodule

// File: rtl/tvs_sqrt.sv
// ----------------------------------------------------------------------------
// tvs_sqrt
// Pipelined floor square root, two result bits per stage, then alignment.
// ----------------------------------------------------------------------------
module tvs_sqrt import tvs_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] rad,
	output logic [15:0] root
);

	sq_t sq_q [CORE_STAGES];
	sq_t sq_d [CORE_STAGES];

	always_comb begin
		sq_t tmp;
		for (int i = 0; i < CORE_STAGES; i++) begin
			if (i == 0) begin
				tmp.x    = rad;
				tmp.rem  = '0;
				tmp.root = '0;
			end else begin
				tmp = sq_q[i-1];
			end
			if (i < SQ_WORK) begin
				for (int j = 0; j < STEPS_PER_STAGE; j++) begin
					tmp = sq_step(tmp);
				end
			end
			sq_d[i] = tmp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CORE_STAGES; i++) begin
				sq_q[i] <= sq_d[i];
			end
		end
	end

	assign root = sq_q[CORE_STAGES-1].root;

endmodule

// File: rtl/tvs_div.sv
// ----------------------------------------------------------------------------
// tvs_div
// Pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module tvs_div import tvs_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [34:0] dvd,
	input  logic [15:0] dvs,
	output logic [19:0] quo
);

	dv_t dv_q [CORE_STAGES];
	dv_t dv_d [CORE_STAGES];

	always_comb begin
		dv_t tmp;
		for (int i = 0; i < CORE_STAGES; i++) begin
			if (i == 0) begin
				tmp.num = dvd[19:0];
				tmp.rem = {2'b00, dvd[34:20]};
				tmp.quo = '0;
				tmp.dvs = dvs;
			end else begin
				tmp = dv_q[i-1];
			end
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				tmp = dv_step(tmp);
			end
			dv_d[i] = tmp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CORE_STAGES; i++) begin
				dv_q[i] <= dv_d[i];
			end
		end
	end

	assign quo = dv_q[CORE_STAGES-1].quo;

endmodule

// File: rtl/tvs_back.sv
// ----------------------------------------------------------------------------
// tvs_back
// Leg select, mirror back, saturate, and the output register.
// ----------------------------------------------------------------------------
module tvs_back import tvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld,
	input  side_t              side,
	input  logic [19:0]        quo,
	input  logic [15:0]        root,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [15:0] speed,
	output logic [2:0]         phase
);

	logic signed [20:0] q3, t3, s, sn;
	logic signed [18:0] r1, r2;
	logic [2:0]         ph;
	logic signed [15:0] sat;

	always_comb begin
		q3 = 21'(side.base3) + $signed({1'b0, quo}) - 21'sd262144;
		t3 = $signed({4'b0000, root, 1'b0}) + 21'(side.w);
		r1 = $signed({3'b000, root});
		r2 = $signed({2'b00, root, 1'b0});
		if (side.zero) begin
			s  = '0;
			ph = PH_ZERO;
		end else if (side.trap) begin
			if (side.ph1t) begin
				s  = 21'(side.s1);
				ph = PH_ACCEL;
			end else if (side.cmp2) begin
				s  = $signed({5'b00000, side.vm});
				ph = PH_CRUISE;
			end else if (side.cmp3) begin
				s  = q3;
				ph = PH_DECEL;
			end else begin
				s  = 21'(side.vf);
				ph = PH_ARRIVED;
			end
		end else begin
			if (r1 >= side.u1) begin
				s  = 21'(side.s1);
				ph = PH_ACCEL;
			end else if (r2 >= side.u3) begin
				s  = t3;
				ph = PH_DECEL;
			end else begin
				s  = 21'(side.vf);
				ph = PH_ARRIVED;
			end
		end
		sn = side.neg ? -s : s;
		if (sn > 21'sd32767) begin
			sat = 16'sh7fff;
		end else if (sn < -21'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = sn[15:0];
		end
	end

	logic               valid_q;
	logic signed [15:0] speed_q;
	logic [2:0]         phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en && vld) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld) begin
			speed_q <= sat;
			phase_q <= ph;
		end
	end

	assign out_valid = valid_q;
	assign speed     = speed_q;
	assign phase     = phase_q;

endmodule

// File: rtl/trapezoid_velocity_step.sv
// ----------------------------------------------------------------------------
// trapezoid_velocity_step
// Plans a trapezoidal or triangular speed profile for one axis request and
// returns the speed and leg at the look-ahead time.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    start_speed, distance
//   out       out_valid / out_ready  speed, phase
//   cfg       cfg_write              cfg_index, cfg_data
//
// One request per cycle while the pipeline is not stalled; an accepted request
// passes five front stages, ten root and quotient stages (20 quotient bits,
// two per stage), and the output register.
// Reset clears the stage valid bits and the output valid, and loads the configuration registers with their defaults.
// A stall holds the whole pipeline only once the last stage and the output
// register are both full; until then every stage advances, bubbles included.
// ----------------------------------------------------------------------------
module trapezoid_velocity_step import tvs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] start_speed,
	input  logic signed [16:0] distance,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] speed,
	output logic [2:0]         phase,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	cfg_t  cfg_q;
	logic  en;
	logic  vld_q [PIPE_STAGES];
	side_t side_q [CORE_STAGES];
	side_t side5;
	logic [34:0] dvd;
	logic [15:0] dvs;
	logic [31:0] rad;
	logic [19:0] quo;
	logic [15:0] root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed   <= 15'd4096;
			cfg_q.min_speed   <= -16'sd4096;
			cfg_q.max_accel   <= 16'd4096;
			cfg_q.final_speed <= 16'sd0;
			cfg_q.look_ahead  <= 16'd3277;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAX_SPEED:   cfg_q.max_speed   <= cfg_data[14:0];
				REG_MIN_SPEED:   cfg_q.min_speed   <= cfg_data;
				REG_MAX_ACCEL:   cfg_q.max_accel   <= cfg_data;
				REG_FINAL_SPEED: cfg_q.final_speed <= cfg_data;
				REG_LOOK_AHEAD:  cfg_q.look_ahead  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !vld_q[PIPE_STAGES-1] || !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_STAGES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < PIPE_STAGES; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	tvs_front u_front (
		.clk        (clk),
		.en         (en),
		.cfg        (cfg_q),
		.start_speed(start_speed),
		.distance   (distance),
		.side       (side5),
		.dvd        (dvd),
		.dvs        (dvs),
		.rad        (rad)
	);

	tvs_sqrt u_sqrt (
		.clk (clk),
		.en  (en),
		.rad (rad),
		.root(root)
	);

	tvs_div u_div (
		.clk(clk),
		.en (en),
		.dvd(dvd),
		.dvs(dvs),
		.quo(quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side5;
			for (int i = 1; i < CORE_STAGES; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	tvs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (vld_q[PIPE_STAGES-1]),
		.side     (side_q[CORE_STAGES-1]),
		.quo      (quo),
		.root     (root),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.speed    (speed),
		.phase    (phase)
	);

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for trapezoid_velocity_step. Drives axis requests with
// random gaps and output stalls, predicts speed and phase of every request
// in integer arithmetic, and compares results in order.
// ----------------------------------------------------------------------------
module tb import tvs_pkg::*; ();

	typedef struct {
		logic signed [15:0] spd;
		logic [2:0]         ph;
	} result_t;

	class profile_scoreboard;
		longint unsigned cap_speed;
		longint          floor_speed;
		longint unsigned accel;
		longint          end_speed;
		longint unsigned sample_t;
		result_t         pending[$];
		int              errors;

		function new();
			cap_speed   = 4096;
			floor_speed = -4096;
			accel       = 4096;
			end_speed   = 0;
			sample_t    = 3277;
			errors      = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_MAX_SPEED:   cap_speed   = val[14:0];
				REG_MIN_SPEED:   floor_speed = $signed(val);
				REG_MAX_ACCEL:   accel       = val;
				REG_FINAL_SPEED: end_speed   = $signed(val);
				REG_LOOK_AHEAD:  sample_t    = val;
				default: ;
			endcase
		endfunction

		function longint fdiv(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0)
				q--;
			return q;
		endfunction

		function longint rdiv(longint n, longint d);
			if (d <= 0)
				return 0;
			return fdiv(2 * n + d, 2 * d);
		endfunction

		function longint root_floor(longint x);
			longint r;
			r = longint'($sqrt(real'(x)));
			while (r * r > x)
				r--;
			while ((r + 1) * (r + 1) <= x)
				r++;
			return r;
		endfunction

		function void note_request(logic signed [15:0] v_in, logic signed [16:0] d_in);
			longint  v0, d, vf, a, at, vm, s, two_ad, k, n, lhs, e2, e3, r, vp;
			longint  p;
			bit      neg;
			result_t res;
			p  = 65536;
			v0 = v_in;
			d  = d_in;
			vf = end_speed;
			a  = (accel != 0) ? longint'(accel) : 1;
			if (d == 0) begin
				res.spd = 0;
				res.ph  = PH_ZERO;
				pending = {pending, res};
				return;
			end
			neg = d < 0;
			if (neg) begin
				vm = (floor_speed > 0) ? 0 : -floor_speed;
				d  = -d;
				v0 = -v0;
				vf = -vf;
			end else begin
				vm = longint'(cap_speed);
			end
			at     = a * longint'(sample_t);
			two_ad = 2 * a * d;
			k      = 2 * vm * vm - v0 * v0 - vf * vf;
			if (two_ad > k) begin
				n   = two_ad - k;
				lhs = 2 * vm * at;
				e2  = 2 * vm * (vm - v0) * p + n * p;
				e3  = e2 + 2 * vm * (vm - vf) * p;
				if (at <= (vm - v0) * p) begin
					s = rdiv(v0 * p + at, p);
					res.ph = PH_ACCEL;
				end else if (lhs <= e2) begin
					s = vm;
					res.ph = PH_CRUISE;
				end else if (lhs <= e3) begin
					s = rdiv((2 * vm - v0) * 2 * vm * p + n * p - at * 2 * vm, 2 * vm * p);
					res.ph = PH_DECEL;
				end else begin
					s = vf;
					res.ph = PH_ARRIVED;
				end
			end else begin
				r = two_ad + v0 * v0 + vf * vf;
				if (r < 0)
					r = 0;
				vp = root_floor(r / 2);
				if (at <= (vp - v0) * p) begin
					s = rdiv(v0 * p + at, p);
					res.ph = PH_ACCEL;
				end else if (at <= (2 * vp - v0 - vf) * p) begin
					s = rdiv((2 * vp - v0) * p - at, p);
					res.ph = PH_DECEL;
				end else begin
					s = vf;
					res.ph = PH_ARRIVED;
				end
			end
			if (neg)
				s = -s;
			if (s > 32767)
				s = 32767;
			if (s < -32768)
				s = -32768;
			res.spd = 16'(s);
			pending = {pending, res};
		endfunction

		function void check_result(logic signed [15:0] spd, logic [2:0] ph);
			result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result speed %0d phase %0d", $time, spd, ph);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (spd !== exp_r.spd) begin
				$display("%0t: speed expected %0d actual %0d", $time, exp_r.spd, spd);
				errors++;
			end
			if (ph !== exp_r.ph) begin
				$display("%0t: phase expected %0d actual %0d", $time, exp_r.ph, ph);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG = 20000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] start_speed;
	logic signed [16:0] distance;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] speed;
	logic [2:0]         phase;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	profile_scoreboard sb;
	int  idle_pct;
	bit  hold_off;
	int  quiet;

	trapezoid_velocity_step u_top (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		sb = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		start_speed = '0;
		distance    = '0;
		out_ready   = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		idle_pct    = 12;
		hold_off    = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// accept results with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(speed, phase);
			out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(logic signed [15:0] v, logic signed [16:0] d);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		start_speed <= v;
		distance    <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(v, d);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_regs(int mode);
		case (mode)
			0: begin
				write_reg(REG_MAX_SPEED, 16'd32767);
				write_reg(REG_MIN_SPEED, 16'h8000);
				write_reg(REG_MAX_ACCEL, 16'd65535);
				write_reg(REG_FINAL_SPEED, 16'h7fff);
				write_reg(REG_LOOK_AHEAD, 16'd65535);
			end
			1: begin
				write_reg(REG_MAX_SPEED, 16'd0);
				write_reg(REG_MIN_SPEED, 16'd0);
				write_reg(REG_MAX_ACCEL, 16'd1);
				write_reg(REG_FINAL_SPEED, 16'h8000);
				write_reg(REG_LOOK_AHEAD, 16'd1);
			end
			2: begin
				write_reg(REG_MAX_SPEED, 16'($urandom_range(32767)));
				write_reg(REG_MIN_SPEED, 16'(-$urandom_range(32768)));
				write_reg(REG_MAX_ACCEL, 16'($urandom_range(1, 65535)));
				write_reg(REG_FINAL_SPEED, 16'($urandom));
				write_reg(REG_LOOK_AHEAD, 16'($urandom_range(1, 65535)));
			end
			default: begin
				write_reg(REG_MAX_SPEED, 16'($urandom_range(1024, 12288)));
				write_reg(REG_MIN_SPEED, 16'(-$urandom_range(1024, 12288)));
				write_reg(REG_MAX_ACCEL, 16'($urandom_range(256, 16384)));
				write_reg(REG_FINAL_SPEED, 16'($urandom_range(0, 1024) - 512));
				write_reg(REG_LOOK_AHEAD, 16'($urandom_range(1, 65535)));
			end
		endcase
	endtask

	initial begin
		int v;
		int d;
		@(posedge arst_n);
		@(posedge clk);
		send_request(16'sd0, 17'sd0);
		send_request(16'sd4096, 17'sd65535);
		send_request(-16'sd4096, -17'sd65536);
		send_request(16'sh7fff, 17'sd1);
		send_request(16'sh8000, -17'sd1);
		send_request(16'sd0, 17'sd100);
		send_request(16'sd0, 17'sd4096);
		send_request(16'sd8192, 17'sd8192);
		send_request(-16'sd8192, 17'sd300);
		drain();
		random_regs(0);
		send_request(16'sh7fff, 17'sd65535);
		send_request(16'sh8000, -17'sd65536);
		send_request(16'sd0, 17'sd1);
		send_request(16'sh8000, 17'sd65535);
		send_request(16'sd0, 17'sd0);
		drain();
		random_regs(1);
		send_request(16'sd0, 17'sd5);
		send_request(16'sd0, -17'sd5);
		send_request(16'sd1000, 17'sd65535);
		send_request(16'sh8000, 17'sh0ffff);
		send_request(16'sh7fff, -17'sd65536);
		drain();
		// long output hold-off to fill the pipeline
		hold_off = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 40; i++)
				send_request(16'($urandom), 17'($urandom));
		join
		drain();
		for (int phs = 0; phs < 12; phs++) begin
			random_regs(phs < 2 ? phs : ((phs % 3 == 0) ? 2 : 3));
			idle_pct = (phs == 5) ? 0 : 12;
			for (int i = 0; i < 125; i++) begin
				if ($urandom_range(3) == 0) begin
					v = $signed(16'($urandom));
					d = $signed(17'($urandom));
				end else begin
					v = $urandom_range(0, 8192) - 4096;
					d = $urandom_range(0, 20000) - 10000;
				end
				send_request(16'(v), 17'(d));
			end
			drain();
		end
		repeat (30) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tvs_pkg.sv
rtl/tvs_front.sv
rtl/tvs_sqrt.sv
rtl/tvs_div.sv
rtl/tvs_back.sv
rtl/trapezoid_velocity_step.sv
sim/tb.sv
